// ===== hdl/aokt_pkg.sv =====
// Shared constants, codes and control types of the key translation table.
package aokt_pkg;

   localparam int SLOTS   = 1024;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int COUNT_W = $clog2(SLOTS + 1);
   localparam int KEY_W   = 32;
   localparam int FUNC_W  = 2;

   localparam logic [KEY_W-1:0] OUTWARD_BASE = 32'h4000_0000;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND  = 2'd0,
      FUNC_FORWARD = 2'd1,
      FUNC_REVERSE = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ADDR_FILL,
      ADDR_SLOT,
      ADDR_TOP,
      ADDR_NEXT
   } addr_sel_type;

   typedef enum logic [2:0] {
      RSP_FAIL,
      RSP_ASSIGNED,
      RSP_STORED,
      RSP_INVALID,
      RSP_FOUND
   } rsp_sel_type;

   typedef struct packed {
      logic         latch;
      logic         append;
      logic         scan_load;
      addr_sel_type addr_sel;
      logic         rsp_load;
      rsp_sel_type  rsp_sel;
   } dp_cmd_type;

   typedef struct packed {
      func_type func;
      logic     full;
      logic     fwd_in_range;
      logic     rev_trivial;
      logic     hit;
      logic     scan_last;
   } dp_status_type;

endpackage

// ===== hdl/append_only_key_translation_table.sv =====
// Top level of the append-only key translation table.
//
//   Channel   Ports                                  Transaction
//   request   start, busy, req_*                     start high while busy low
//   response  rsp_strobe, rsp_ok, rsp_key_out        one cycle with rsp_strobe high
//   csr       csr_valid, csr_ready, csr_wdata        csr_valid and csr_ready high
//
// Append answers from the execute state; forward lookup passes through the read-wait state when
// the slot is in range and answers from the execute state otherwise.
// Reverse lookup answers from the execute state when trivial, else it scans: the scan reads one key store
// entry per cycle through the single RAM port, newest first, and stops at the first match.
// A new request is accepted in the cycle that shows the previous response.
// Reset clears the fill count and the invalid code; the key store is not cleared.
// The receiver cannot stall the response, and the csr port is always ready.
module append_only_key_translation_table
   import aokt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic signed [KEY_W-1:0] req_impl_key,
   input  logic signed [KEY_W-1:0] req_outward_key,
   output logic                    rsp_strobe,
   output logic                    rsp_ok,
   output logic signed [KEY_W-1:0] rsp_key_out,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic signed [KEY_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type sts;

   assign csr_ready = 1'b1;

   aokt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .sts        (sts)
   );

   aokt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_impl_key    (req_impl_key),
      .req_outward_key (req_outward_key),
      .csr_valid       (csr_valid),
      .csr_wdata       (csr_wdata),
      .rsp_ok          (rsp_ok),
      .rsp_key_out     (rsp_key_out)
   );

endmodule

// ===== hdl/aokt_ram.sv =====
// Generic single-port RAM with registered read data.
module aokt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/aokt_dp.sv =====
// Datapath: operand registers, fill count, key store, scan pointer and result registers.
module aokt_dp
   import aokt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_status_type           sts,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic signed [KEY_W-1:0] req_impl_key,
   input  logic signed [KEY_W-1:0] req_outward_key,
   input  logic                    csr_valid,
   input  logic [KEY_W-1:0]        csr_wdata,
   output logic                    rsp_ok,
   output logic signed [KEY_W-1:0] rsp_key_out
);

   func_type           func_ff;
   logic [KEY_W-1:0]   impl_key_ff;
   logic [KEY_W-1:0]   outward_key_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [KEY_W-1:0]   invalid_ff;
   logic [SLOT_W-1:0]  ptr_ff;
   logic               ok_ff;
   logic               ok_in;
   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   key_in;

   logic [SLOT_W-1:0]  ram_addr;
   logic [KEY_W-1:0]   ram_rd_data;
   logic [COUNT_W-1:0] count_dec;
   logic [KEY_W:0]     fwd_diff;
   logic [KEY_W-1:0]   count_wide;
   logic [KEY_W-1:0]   ptr_wide;

   assign count_dec  = count_ff - COUNT_W'(1);
   assign count_wide = {{(KEY_W-COUNT_W){1'b0}}, count_ff};
   assign ptr_wide   = {{(KEY_W-SLOT_W){1'b0}}, ptr_ff};
   // Slot of a forward lookup; the top bit is set when the key lies below the base.
   assign fwd_diff   = {outward_key_ff[KEY_W-1], outward_key_ff} - {1'b0, OUTWARD_BASE};

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_FILL: ram_addr = count_ff[SLOT_W-1:0];
         ADDR_SLOT: ram_addr = fwd_diff[SLOT_W-1:0];
         ADDR_TOP:  ram_addr = count_dec[SLOT_W-1:0];
         ADDR_NEXT: ram_addr = ptr_ff - SLOT_W'(1);
         default:   ram_addr = count_ff[SLOT_W-1:0];
      endcase
   end

   aokt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (SLOTS)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (cmd.append),
      .addr    (ram_addr),
      .wr_data (impl_key_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      sts.func         = func_ff;
      sts.full         = (count_ff == COUNT_W'(SLOTS));
      sts.fwd_in_range = !fwd_diff[KEY_W] && (fwd_diff[KEY_W-1:0] < count_wide);
      sts.rev_trivial  = (impl_key_ff == '0) || (count_ff == '0);
      sts.hit          = (ram_rd_data == impl_key_ff);
      sts.scan_last    = (ptr_ff == '0);
   end

   always_comb begin
      count_in = cmd.append ? count_ff + COUNT_W'(1) : count_ff;
      unique case (cmd.rsp_sel)
         RSP_FAIL: begin
            ok_in  = 1'b0;
            key_in = '0;
         end
         RSP_ASSIGNED: begin
            ok_in  = 1'b1;
            key_in = OUTWARD_BASE + count_wide;
         end
         RSP_STORED: begin
            ok_in  = 1'b1;
            key_in = ram_rd_data;
         end
         RSP_INVALID: begin
            ok_in  = 1'b0;
            key_in = invalid_ff;
         end
         RSP_FOUND: begin
            ok_in  = 1'b1;
            key_in = OUTWARD_BASE + ptr_wide;
         end
         default: begin
            ok_in  = 1'b0;
            key_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         invalid_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (csr_valid) begin
            invalid_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff        <= func_type'(req_func);
         impl_key_ff    <= req_impl_key;
         outward_key_ff <= req_outward_key;
      end
      // The pointer follows the address just read, so it names the slot of the read data.
      if (cmd.scan_load) begin
         ptr_ff <= ram_addr;
      end
      if (cmd.rsp_load) begin
         ok_ff  <= ok_in;
         key_ff <= key_in;
      end
   end

   assign rsp_ok      = ok_ff;
   assign rsp_key_out = key_ff;

endmodule

// ===== hdl/aokt_ctrl.sv =====
// Controller: sequences append, forward lookup and the newest-first reverse scan.
module aokt_ctrl
   import aokt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_strobe,
   output dp_cmd_type    cmd,
   input  dp_status_type sts
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FWD_WAIT,
      S_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      strobe_ff;
   logic      strobe_in;

   always_comb begin
      state_in      = state_ff;
      strobe_in     = 1'b0;
      cmd.latch     = 1'b0;
      cmd.append    = 1'b0;
      cmd.scan_load = 1'b0;
      cmd.addr_sel  = ADDR_FILL;
      cmd.rsp_load  = 1'b0;
      cmd.rsp_sel   = RSP_FAIL;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (sts.func)
               FUNC_APPEND: begin
                  cmd.rsp_load = 1'b1;
                  strobe_in    = 1'b1;
                  state_in     = S_IDLE;
                  if (!sts.full) begin
                     cmd.append  = 1'b1;
                     cmd.rsp_sel = RSP_ASSIGNED;
                  end
               end
               FUNC_FORWARD: begin
                  cmd.addr_sel = ADDR_SLOT;
                  if (sts.fwd_in_range) begin
                     state_in = S_FWD_WAIT;
                  end else begin
                     cmd.rsp_load = 1'b1;
                     strobe_in    = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               FUNC_REVERSE: begin
                  if (sts.rev_trivial) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = RSP_INVALID;
                     strobe_in    = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     cmd.addr_sel  = ADDR_TOP;
                     cmd.scan_load = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               default: begin
                  cmd.rsp_load = 1'b1;
                  strobe_in    = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_FWD_WAIT: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = RSP_STORED;
            strobe_in    = 1'b1;
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            // Compare the entry read last cycle while reading the next older one.
            priority if (sts.hit) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_FOUND;
               strobe_in    = 1'b1;
               state_in     = S_IDLE;
            end else if (sts.scan_last) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_INVALID;
               strobe_in    = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.addr_sel  = ADDR_NEXT;
               cmd.scan_load = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule
